@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the rolling window aggregate.
// No dependencies; simulation-only bodies, empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RWA_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rolling_window_aggregate: check failed");
`define RWA_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rolling_window_aggregate: forbidden condition");
`else
`define RWA_ASSERT(name, clk, rst, prop)
`define RWA_NEVER(name, clk, rst, cond)
`endif
`endif

@@ hdl/rwa_pkg.sv @@
// Shared widths, codes and constants for the rolling window aggregate.
// No dependencies.
`default_nettype none
package rwa_pkg;

  localparam int WIN_MAX  = 16;
  localparam int IDX_W    = 4;
  localparam int LEN_W    = 5;
  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 16;
  localparam int FRAC     = 12;
  localparam int TERM_W   = 32;
  localparam int ACC_W    = 36;
  localparam int MAG_W    = 60;
  localparam int HALF_W   = 30;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int VAL_W    = 48;
  localparam int DIV_W    = ACC_W - FRAC;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [2:0] CFG_WINDOW_LEN  = 3'd0;
  localparam logic [2:0] CFG_OP_MODE     = 3'd1;
  localparam logic [2:0] CFG_USE_WEIGHTS = 3'd2;
  localparam logic [2:0] CFG_FILL_MODE   = 3'd3;
  localparam logic [2:0] CFG_STRIDE      = 3'd4;
  localparam logic [2:0] CFG_FILL_LEFT   = 3'd5;
  localparam logic [2:0] CFG_FILL_MIDDLE = 3'd6;
  localparam logic [2:0] CFG_FILL_RIGHT  = 3'd7;

  localparam logic [2:0] OP_SUM  = 3'd0;
  localparam logic [2:0] OP_MEAN = 3'd1;
  localparam logic [2:0] OP_MIN  = 3'd2;
  localparam logic [2:0] OP_MAX  = 3'd3;
  localparam logic [2:0] OP_PROD = 3'd4;

  localparam logic [1:0] FILL_NONE   = 2'd0;
  localparam logic [1:0] FILL_LEFT   = 2'd1;
  localparam logic [1:0] FILL_CENTER = 2'd2;
  localparam logic [1:0] FILL_RIGHT  = 2'd3;

  typedef enum logic [2:0] {
    KIND_LPAD   = 3'd0,
    KIND_WINDOW = 3'd1,
    KIND_SKIP   = 3'd2,
    KIND_RPAD   = 3'd3,
    KIND_SHORT  = 3'd4
  } kind_t;

endpackage
`default_nettype wire

@@ hdl/rwa_mul.sv @@
// Shared registered signed multiplier, one product per cycle.
// Depends on rwa_pkg for operand widths.
`default_nettype none
module rwa_mul (
  input  wire                                    clk,
  input  wire  signed [rwa_pkg::MUL_W-1:0]       a,
  input  wire  signed [rwa_pkg::MUL_W-1:0]       b,
  output logic signed [rwa_pkg::PROD_W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

@@ hdl/rwa_div.sv @@
// Restoring divider, one quotient bit per cycle, window length divisor.
// Depends on rwa_pkg for widths.
`default_nettype none
module rwa_div (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire  [rwa_pkg::DIV_W-1:0]        dividend,
  input  wire  [rwa_pkg::LEN_W-1:0]        divisor,
  output logic                             busy,
  output logic                             done,
  output logic [rwa_pkg::DIV_W-1:0]        quotient
);

  logic [rwa_pkg::LEN_W-1:0]     rem;
  logic [rwa_pkg::LEN_W:0]       trial;
  logic                          fits;
  logic [rwa_pkg::DIV_CNT_W-1:0] count;

  assign trial = {rem, quotient[rwa_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        rem      <= '0;
        count    <= rwa_pkg::DIV_CNT_W'(rwa_pkg::DIV_W);
        busy     <= 1'b1;
      end else if (busy) begin
        // remainder stays below the divisor, so it fits LEN_W bits
        rem      <= fits ? rwa_pkg::LEN_W'(trial - {1'b0, divisor})
                         : trial[rwa_pkg::LEN_W-1:0];
        quotient <= {quotient[rwa_pkg::DIV_W-2:0], fits};
        count    <= count - 1'b1;
        if (count == rwa_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/rolling_window_aggregate.sv @@
// Rolling window aggregate: top level, sequencer, window and weight stores.
// Depends on rwa_pkg, rwa_mul, rwa_div and assert_macros.svh.
// Sequence: a weight write is taken while idle; a sample emits any left pads, then a skipped
// or computed window (entries walk S_RD, S_MUL, S_ACC; product adds S_P0, S_P1, S_P2; mean adds
// a 24-step divide), then right pads or a short marker at series end; out_ready can stall outputs.
// Reset (synchronous, rst high): control state cleared, registers to defaults.
`default_nettype none
`include "assert_macros.svh"
module rolling_window_aggregate (
  input  wire                                 clk,
  input  wire                                 rst,
  // configuration write port
  input  wire                                 cfg_we,
  input  wire  [2:0]                          cfg_index,
  input  wire  [rwa_pkg::VAL_W-1:0]           cfg_data,
  // input channel
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 req_type,
  input  wire  signed [rwa_pkg::SAMPLE_W-1:0] sample,
  input  wire                                 series_end,
  input  wire  [rwa_pkg::IDX_W-1:0]           weight_index,
  input  wire  signed [rwa_pkg::WEIGHT_W-1:0] weight_value,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [rwa_pkg::VAL_W-1:0]    value,
  output logic [2:0]                          kind,
  output logic                                last
);

  localparam int IDX_W  = rwa_pkg::IDX_W;
  localparam int LEN_W  = rwa_pkg::LEN_W;
  localparam int ACC_W  = rwa_pkg::ACC_W;
  localparam int TERM_W = rwa_pkg::TERM_W;
  localparam int MAG_W  = rwa_pkg::MAG_W;
  localparam int HALF_W = rwa_pkg::HALF_W;
  localparam int MUL_W  = rwa_pkg::MUL_W;
  localparam int VAL_W  = rwa_pkg::VAL_W;
  localparam int FRAC   = rwa_pkg::FRAC;
  localparam int FULL_W = 2 * HALF_W + TERM_W;

  localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(1) << FRAC;
  localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << (VAL_W - 1 + FRAC);
  localparam logic signed [VAL_W-1:0] POS48 = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] NEG48 = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [MUL_W-1:0] W_ONE = MUL_W'(1) << FRAC;

  typedef enum logic [3:0] {
    S_IDLE, S_LPAD, S_RD, S_MUL, S_ACC, S_P0, S_P1, S_P2,
    S_FIN, S_DIV, S_WIN, S_END
  } state_t;

  // configuration registers
  logic [4:0]              window_len;
  logic [2:0]              op_mode;
  logic                    use_weights;
  logic [1:0]              fill_mode;
  logic [7:0]              stride;
  logic signed [VAL_W-1:0] fill_left;
  logic signed [VAL_W-1:0] fill_middle;
  logic signed [VAL_W-1:0] fill_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len  <= 5'd1;
      op_mode     <= rwa_pkg::OP_SUM;
      use_weights <= 1'b0;
      fill_mode   <= rwa_pkg::FILL_NONE;
      stride      <= 8'd1;
      fill_left   <= '0;
      fill_middle <= '0;
      fill_right  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rwa_pkg::CFG_WINDOW_LEN:  window_len  <= cfg_data[4:0];
        rwa_pkg::CFG_OP_MODE:     op_mode     <= cfg_data[2:0];
        rwa_pkg::CFG_USE_WEIGHTS: use_weights <= cfg_data[0];
        rwa_pkg::CFG_FILL_MODE:   fill_mode   <= cfg_data[1:0];
        rwa_pkg::CFG_STRIDE:      stride      <= cfg_data[7:0];
        rwa_pkg::CFG_FILL_LEFT:   fill_left   <= cfg_data;
        rwa_pkg::CFG_FILL_MIDDLE: fill_middle <= cfg_data;
        rwa_pkg::CFG_FILL_RIGHT:  fill_right  <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t                   state;
  logic [IDX_W-1:0]         wp;          // write pointer
  logic [LEN_W-1:0]         seen;        // samples seen, saturating
  logic [7:0]               phase;       // stride phase
  logic [LEN_W-1:0]         lpad_left;
  logic [LEN_W-1:0]         rpad_left;
  logic                     end_r, short_r, win_r, calc_r;
  logic [LEN_W-1:0]         n_r;
  logic [IDX_W-1:0]         base_r;      // oldest window entry
  logic [LEN_W-1:0]         agg_i;
  logic signed [ACC_W-1:0]  sum;
  logic signed [TERM_W-1:0] best;
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [TERM_W-2:0]        tabs;
  logic [2*HALF_W+1:0]      plo;
  logic signed [VAL_W-1:0]  agg_val;

  // stores
  logic signed [rwa_pkg::SAMPLE_W-1:0] window_store [rwa_pkg::WIN_MAX];
  logic signed [rwa_pkg::WEIGHT_W-1:0] weight_table [rwa_pkg::WIN_MAX];
  logic signed [rwa_pkg::SAMPLE_W-1:0] win_q;
  logic signed [rwa_pkg::WEIGHT_W-1:0] wgt_q;

  logic in_xfer, out_free;
  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (in_xfer && !req_type) window_store[wp] <= sample;
    if (state == S_RD) win_q <= window_store[base_r + agg_i[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && req_type) weight_table[weight_index] <= weight_value;
    if (state == S_RD) wgt_q <= weight_table[agg_i[IDX_W-1:0]];
  end

  // sample bookkeeping, evaluated for the item being accepted
  logic [LEN_W-1:0] n_eff, seen_new, lpads, rpads;
  logic [7:0]       st_eff, ph;
  logic [8:0]       ph_inc;
  logic             have_win;
  logic [IDX_W-1:0] wp_inc;

  always_comb begin
    n_eff = (window_len == '0) ? LEN_W'(1)
          : (window_len > LEN_W'(rwa_pkg::WIN_MAX)) ? LEN_W'(rwa_pkg::WIN_MAX)
          : window_len;
    st_eff   = (stride == 8'd0) ? 8'd1 : stride;
    seen_new = (seen < n_eff) ? seen + 1'b1 : seen;
    have_win = seen_new >= n_eff;
    ph       = (phase >= st_eff) ? 8'd0 : phase;
    ph_inc   = {1'b0, ph} + 9'd1;
    wp_inc   = wp + 1'b1;
    case (fill_mode)
      rwa_pkg::FILL_CENTER: lpads = (n_eff - 1'b1) >> 1;
      rwa_pkg::FILL_RIGHT:  lpads = n_eff - 1'b1;
      default:              lpads = '0;
    endcase
    case (fill_mode)
      rwa_pkg::FILL_LEFT:   rpads = n_eff - 1'b1;
      rwa_pkg::FILL_CENTER: rpads = n_eff >> 1;
      default:              rpads = '0;
    endcase
  end

  // shared multiplier: window terms and the product's partial products
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [2*MUL_W-1:0]  mul_p;
  logic signed [TERM_W-1:0]   term;
  logic [TERM_W-1:0]          term_abs;

  always_comb begin
    unique case (state)
      S_P0: begin
        mul_a = MUL_W'(mag[HALF_W-1:0]);
        mul_b = MUL_W'(tabs);
      end
      S_P1: begin
        mul_a = MUL_W'(mag[MAG_W-1:HALF_W]);
        mul_b = MUL_W'(tabs);
      end
      default: begin
        mul_a = MUL_W'(win_q);
        mul_b = use_weights ? MUL_W'(wgt_q) : W_ONE;
      end
    endcase
  end

  rwa_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  assign term     = mul_p[TERM_W-1:0];
  assign term_abs = term[TERM_W-1] ? TERM_W'(-term) : TERM_W'(term);

  // product step: (mag * |t|) >> FRAC, clamped at the cap
  logic [FULL_W-1:0]     full;
  logic [FULL_W-FRAC-1:0] shr;
  logic [MAG_W-1:0]      mag_next;
  assign full     = (FULL_W'(mul_p[2*HALF_W+1:0]) << HALF_W) + FULL_W'(plo);
  assign shr      = full[FULL_W-1:FRAC];
  assign mag_next = (|shr[FULL_W-FRAC-1:MAG_W] || shr[MAG_W-1:0] > MAG_CAP)
                    ? MAG_CAP : shr[MAG_W-1:0];

  function automatic logic signed [ACC_W-1:0] trunc_frac(
    input logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] m;
    m = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    m = m >> FRAC;
    return x[ACC_W-1] ? -signed'(m) : signed'(m);
  endfunction

  // final value for the product mode
  logic [VAL_W-1:0]        prod_q;
  logic signed [VAL_W-1:0] prod_val;
  assign prod_q = mag[MAG_W-1:FRAC];
  always_comb begin
    if (neg) prod_val = prod_q[VAL_W-1] ? NEG48 : -signed'(prod_q);
    else     prod_val = prod_q[VAL_W-1] ? POS48 : signed'(prod_q);
  end

  // mean: |sum| >> FRAC divided by the window length
  logic [ACC_W-1:0]         sum_abs;
  logic                     div_start, div_busy, div_done;
  logic [rwa_pkg::DIV_W-1:0] div_q;
  assign sum_abs   = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
  assign div_start = (state == S_FIN) && (op_mode == rwa_pkg::OP_MEAN);

  rwa_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(sum_abs[ACC_W-1:FRAC]), .divisor(n_r),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  logic last_term;
  assign last_term = (agg_i == n_r - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wp        <= '0;
      seen      <= '0;
      phase     <= '0;
      lpad_left <= '0;
      rpad_left <= '0;
      end_r     <= 1'b0;
      short_r   <= 1'b0;
      win_r     <= 1'b0;
      calc_r    <= 1'b0;
      agg_i     <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_xfer && !req_type) begin
            wp        <= series_end ? '0 : wp_inc;
            seen      <= series_end ? '0 : seen_new;
            if (series_end) phase <= '0;
            else if (have_win) phase <= (ph_inc >= {1'b0, st_eff}) ? 8'd0 : ph_inc[7:0];
            lpad_left <= (seen == '0) ? lpads : '0;
            rpad_left <= rpads;
            end_r     <= series_end;
            short_r   <= series_end && !have_win;
            win_r     <= have_win;
            calc_r    <= have_win && (ph == 8'd0);
            n_r       <= n_eff;
            base_r    <= wp_inc - n_eff[IDX_W-1:0];
            agg_i     <= '0;
            sum       <= '0;
            neg       <= 1'b0;
            mag       <= MAG_ONE;
            state     <= S_LPAD;
          end
        end
        S_LPAD: begin
          if (lpad_left == '0) begin
            state <= !win_r ? S_END : (calc_r ? S_RD : S_WIN);
          end else if (out_free) begin
            out_valid <= 1'b1;
            value     <= fill_left;
            kind      <= rwa_pkg::KIND_LPAD;
            last      <= 1'b0;
            lpad_left <= lpad_left - 1'b1;
          end
        end
        S_RD:  state <= S_MUL;
        S_MUL: state <= S_ACC;
        S_ACC: begin
          sum  <= sum + ACC_W'(term);
          if (agg_i == '0 || (op_mode == rwa_pkg::OP_MIN && term < best) ||
              (op_mode == rwa_pkg::OP_MAX && term > best)) begin
            best <= term;
          end
          neg  <= neg ^ term[TERM_W-1];
          tabs <= term_abs[TERM_W-2:0];
          if (op_mode == rwa_pkg::OP_PROD) begin
            state <= S_P0;
          end else if (last_term) begin
            state <= S_FIN;
          end else begin
            agg_i <= agg_i + 1'b1;
            state <= S_RD;
          end
        end
        S_P0: state <= S_P1;
        S_P1: begin
          plo   <= mul_p[2*HALF_W+1:0];
          state <= S_P2;
        end
        S_P2: begin
          mag <= mag_next;
          if (last_term) begin
            state <= S_FIN;
          end else begin
            agg_i <= agg_i + 1'b1;
            state <= S_RD;
          end
        end
        S_FIN: begin
          case (op_mode)
            rwa_pkg::OP_MEAN: state <= S_DIV;
            rwa_pkg::OP_MIN, rwa_pkg::OP_MAX: begin
              agg_val <= VAL_W'(trunc_frac(ACC_W'(best)));
              state   <= S_WIN;
            end
            rwa_pkg::OP_PROD: begin
              agg_val <= prod_val;
              state   <= S_WIN;
            end
            default: begin
              agg_val <= VAL_W'(trunc_frac(sum));
              state   <= S_WIN;
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            agg_val <= sum[ACC_W-1] ? -signed'(VAL_W'(div_q)) : signed'(VAL_W'(div_q));
            state   <= S_WIN;
          end
        end
        S_WIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            value     <= calc_r ? agg_val : fill_middle;
            kind      <= calc_r ? rwa_pkg::KIND_WINDOW : rwa_pkg::KIND_SKIP;
            last      <= end_r && (rpad_left == '0);
            state     <= S_END;
          end
        end
        S_END: begin
          if (!end_r) begin
            state <= S_IDLE;
          end else if (short_r) begin
            if (out_free) begin
              out_valid <= 1'b1;
              value     <= '0;
              kind      <= rwa_pkg::KIND_SHORT;
              last      <= 1'b1;
              state     <= S_IDLE;
            end
          end else if (rpad_left == '0) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid <= 1'b1;
            value     <= fill_right;
            kind      <= rwa_pkg::KIND_RPAD;
            last      <= (rpad_left == LEN_W'(1));
            rpad_left <= rpad_left - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `RWA_NEVER(a_seen_bound, clk, rst, seen > LEN_W'(rwa_pkg::WIN_MAX))
  `RWA_ASSERT(a_div_in_state, clk, rst, div_busy |-> (state == S_DIV))
  `RWA_ASSERT(a_weight_quiet, clk, rst, (in_xfer && req_type) |=> in_ready)

endmodule
`default_nettype wire
